// ===== rtl/vsmppt_pkg.sv =====
// Shared types and constants for the variable-step MPPT tracker.
// No dependencies; used by the top level and its arithmetic units.
package vsmppt_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAX_STEP = 2'd0;
	localparam logic [1:0] CFG_MIN_STEP = 2'd1;

	localparam logic [14:0] MAX_STEP_RESET = 15'd512;
	localparam logic [14:0] MIN_STEP_RESET = 15'd26;

	// Unit widths
	localparam int MUL_W  = 32;
	localparam int DIVN_W = 48;
	localparam int DIVD_W = 32;
	localparam int SQI_W  = 64;
	localparam int SQO_W  = 32;

	localparam logic [30:0] RATIO_MAX = 31'h7FFF_FFFF;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_R_MUL0, ST_R_DIV0, ST_R_MUL1, ST_R_DIV1, ST_R_MUL2, ST_R_DIV2, ST_R_FIN,
		ST_T_DIFF, ST_T_DIV, ST_T_SQP, ST_T_MULC, ST_T_MULA2, ST_T_SQD,
		ST_T_MULS, ST_T_DIVS, ST_T_FIN
	} state_t;

endpackage

// ===== rtl/variable_step_mppt_tracker.sv =====
// Variable-step incremental MPPT tracker, top level with sequencer.
// Depends on vsmppt_pkg, vsmppt_mul, vsmppt_div and vsmppt_sqrt.
//
// Usage:
//   Input channel (in_valid/in_stall): command, voltage, power. command=1 is a
//   restart carrying the start voltage; command=0 is a tracking sample.
//   Output channel (out_valid/out_stall): one result per request with the new
//   reference_voltage, the applied_step and the held flag.
//   Config port: cfg_we/cfg_index/cfg_data write max_step_percent (index 0)
//   and min_step_percent (index 1); other indexes are ignored.
// Sequencing:
//   One request at a time. All arithmetic goes through one bit-serial
//   multiplier, one restoring divider and one square-root unit.
//   A held sample uses no unit; a restart runs three multiply/divide pairs;
//   a full sample runs divide, root, two multiplies, root, multiply, divide,
//   and skips the first divide when the voltage did not change.
//   in_stall is high from acceptance until the result is in the output
//   register; the next request is taken only after that.
// Reset and stall:
//   arst_n clears all tracking state and loads the register defaults.
//   The output register holds a result until taken; a finished computation
//   waits for that slot while out_stall is high.
module variable_step_mppt_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [15:0]         voltage,
	input  logic [23:0]         power,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         reference_voltage,
	output logic signed [16:0]  applied_step,
	output logic                held,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [14:0]         cfg_data
);
	vsmppt_pkg::state_t state_q, state_d;

	// configuration
	logic [14:0] max_pct_q, min_pct_q;

	// tracking state
	logic [15:0] last_voltage_q, reference_q, step_ceiling_q, step_floor_q;
	logic [23:0] last_power_q, tracked_power_q;
	logic [47:0] last_curv_q;

	// request latch and intermediates
	logic [15:0] v_q;
	logic [23:0] p_q;
	logic [30:0] a_q;
	logic [13:0] sp_q;
	logic [44:0] c_q;
	logic [63:0] sqd_in_q;
	logic [31:0] d_q;
	logic [46:0] num_q;
	logic [47:0] s_q;
	logic        launched_q;

	// output register
	logic        out_valid_q, held_q;
	logic [15:0] out_ref_q;
	logic [16:0] out_step_q;

	// unit hookups
	logic        mul_start, mul_busy, mul_done;
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_prod;
	logic        div_start, div_busy, div_done;
	logic [47:0] div_num, div_quo;
	logic [31:0] div_den;
	logic        sq_start, sq_busy, sq_done;
	logic [63:0] sq_x;
	logic [31:0] sq_root;

	vsmppt_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .done(mul_done), .prod(mul_prod)
	);
	vsmppt_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quo(div_quo)
	);
	vsmppt_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(sq_x),
		.busy(sq_busy), .done(sq_done), .root(sq_root)
	);

	// differences against the last sample
	logic        dp_pos, dp_neg, dv_pos, dv_neg, dv_zero;
	logic [23:0] adp;
	logic [15:0] adv;
	logic [30:0] adp100;
	logic        in_band;

	assign dp_pos  = p_q > last_power_q;
	assign dp_neg  = p_q < last_power_q;
	assign dv_pos  = v_q > last_voltage_q;
	assign dv_neg  = v_q < last_voltage_q;
	assign dv_zero = !dv_pos && !dv_neg;
	assign adp     = dp_neg ? last_power_q - p_q : p_q - last_power_q;
	assign adv     = dv_neg ? last_voltage_q - v_q : v_q - last_voltage_q;
	assign adp100  = ({7'd0, adp} << 6) + ({7'd0, adp} << 5) + ({7'd0, adp} << 2);
	assign in_band = (adv < step_floor_q) && (adp100 < {7'd0, tracked_power_q});

	// restart rounding and saturation
	logic [15:0] pct_sat;
	assign pct_sat = (div_quo > 48'd65535) ? 16'hFFFF : div_quo[15:0];

	// final step selection
	logic        r_pos, r_neg, c_pos, c_neg, dc_pos, dc_neg, floored;
	logic [47:0] c_ext, s_eff, mag_raw;
	logic [16:0] floor2;
	logic [15:0] mag;
	logic [16:0] ref_up;
	logic [15:0] ref_new;
	logic [16:0] step_new;

	assign r_pos   = dv_zero ? dp_pos : (a_q != '0) && ((dp_pos && dv_pos) || (dp_neg && dv_neg));
	assign r_neg   = dv_zero ? dp_neg : (a_q != '0) && ((dp_pos && dv_neg) || (dp_neg && dv_pos));
	assign c_ext   = {3'd0, c_q};
	assign c_pos   = c_ext > last_curv_q;
	assign c_neg   = c_ext < last_curv_q;
	assign dc_pos  = dv_zero ? c_pos : ((dv_pos && c_pos) || (dv_neg && c_neg));
	assign dc_neg  = dv_zero ? c_neg : ((dv_pos && c_neg) || (dv_neg && c_pos));
	assign floor2  = {step_floor_q, 1'b0};
	assign floored = s_q < {31'd0, floor2};
	assign s_eff   = floored ? {31'd0, floor2} : s_q;

	always_comb begin
		if (r_pos)
			mag_raw = dc_pos ? {32'd0, step_ceiling_q} : s_eff;
		else if (r_neg)
			mag_raw = dc_neg ? {32'd0, step_ceiling_q} : s_eff;
		else
			mag_raw = '0;
	end

	assign mag      = (mag_raw > 48'd65535) ? 16'hFFFF : mag_raw[15:0];
	assign ref_up   = {1'b0, reference_q} + {1'b0, mag};
	assign step_new = r_neg ? 17'(-{1'b0, mag}) : {1'b0, mag};

	always_comb begin
		if (r_neg)
			ref_new = (reference_q >= mag) ? reference_q - mag : 16'd0;
		else
			ref_new = ref_up[16] ? 16'hFFFF : ref_up[15:0];
	end

	// sequencer: next state and unit operand selection
	logic slot_free, accept, unit_done;
	assign slot_free = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;
	assign in_stall  = state_q != vsmppt_pkg::ST_IDLE;

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		sq_start  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_num   = '0;
		div_den   = 32'd1;
		sq_x      = '0;
		unit_done = 1'b0;
		unique case (state_q)
			vsmppt_pkg::ST_IDLE: begin
				if (accept)
					state_d = command ? vsmppt_pkg::ST_R_MUL0 : vsmppt_pkg::ST_T_DIFF;
			end
			vsmppt_pkg::ST_R_MUL0: begin
				mul_start = !launched_q && !mul_busy;
				mul_a     = {16'd0, v_q};
				mul_b     = 32'd85;
				unit_done = mul_done;
				if (mul_done) state_d = vsmppt_pkg::ST_R_DIV0;
			end
			vsmppt_pkg::ST_R_DIV0: begin
				div_start = !launched_q && !div_busy;
				div_num   = mul_prod[47:0] + 48'd50;
				div_den   = 32'd100;
				unit_done = div_done;
				if (div_done) state_d = vsmppt_pkg::ST_R_MUL1;
			end
			vsmppt_pkg::ST_R_MUL1: begin
				mul_start = !launched_q && !mul_busy;
				mul_a     = {16'd0, v_q};
				mul_b     = {17'd0, max_pct_q};
				unit_done = mul_done;
				if (mul_done) state_d = vsmppt_pkg::ST_R_DIV1;
			end
			vsmppt_pkg::ST_R_DIV1: begin
				div_start = !launched_q && !div_busy;
				div_num   = mul_prod[47:0] + 48'd12800;
				div_den   = 32'd25600;
				unit_done = div_done;
				if (div_done) state_d = vsmppt_pkg::ST_R_MUL2;
			end
			vsmppt_pkg::ST_R_MUL2: begin
				mul_start = !launched_q && !mul_busy;
				mul_a     = {16'd0, v_q};
				mul_b     = {17'd0, min_pct_q};
				unit_done = mul_done;
				if (mul_done) state_d = vsmppt_pkg::ST_R_DIV2;
			end
			vsmppt_pkg::ST_R_DIV2: begin
				div_start = !launched_q && !div_busy;
				div_num   = mul_prod[47:0] + 48'd12800;
				div_den   = 32'd25600;
				unit_done = div_done;
				if (div_done) state_d = vsmppt_pkg::ST_R_FIN;
			end
			vsmppt_pkg::ST_R_FIN: begin
				if (slot_free) state_d = vsmppt_pkg::ST_IDLE;
			end
			vsmppt_pkg::ST_T_DIFF: begin
				if (in_band) begin
					if (slot_free) state_d = vsmppt_pkg::ST_IDLE;
				end else if (dv_zero) begin
					state_d = vsmppt_pkg::ST_T_SQP;
				end else begin
					state_d = vsmppt_pkg::ST_T_DIV;
				end
			end
			vsmppt_pkg::ST_T_DIV: begin
				div_start = !launched_q && !div_busy;
				div_num   = {6'd0, adp, 18'd0};
				div_den   = {16'd0, adv};
				unit_done = div_done;
				if (div_done) state_d = vsmppt_pkg::ST_T_SQP;
			end
			vsmppt_pkg::ST_T_SQP: begin
				sq_start  = !launched_q && !sq_busy;
				sq_x      = {36'd0, p_q, 4'd0};
				unit_done = sq_done;
				if (sq_done) state_d = vsmppt_pkg::ST_T_MULC;
			end
			vsmppt_pkg::ST_T_MULC: begin
				mul_start = !launched_q && !mul_busy;
				mul_a     = {18'd0, sp_q};
				mul_b     = {1'b0, a_q};
				unit_done = mul_done;
				if (mul_done) state_d = vsmppt_pkg::ST_T_MULA2;
			end
			vsmppt_pkg::ST_T_MULA2: begin
				mul_start = !launched_q && !mul_busy;
				mul_a     = {1'b0, a_q};
				mul_b     = {1'b0, a_q};
				unit_done = mul_done;
				if (mul_done) state_d = vsmppt_pkg::ST_T_SQD;
			end
			vsmppt_pkg::ST_T_SQD: begin
				sq_start  = !launched_q && !sq_busy;
				sq_x      = sqd_in_q;
				unit_done = sq_done;
				if (sq_done) state_d = vsmppt_pkg::ST_T_MULS;
			end
			vsmppt_pkg::ST_T_MULS: begin
				mul_start = !launched_q && !mul_busy;
				mul_a     = {1'b0, a_q};
				mul_b     = {16'd0, step_ceiling_q};
				unit_done = mul_done;
				if (mul_done) state_d = vsmppt_pkg::ST_T_DIVS;
			end
			vsmppt_pkg::ST_T_DIVS: begin
				div_start = !launched_q && !div_busy;
				div_num   = {1'b0, num_q};
				div_den   = d_q;
				unit_done = div_done;
				if (div_done) state_d = vsmppt_pkg::ST_T_FIN;
			end
			vsmppt_pkg::ST_T_FIN: begin
				if (slot_free) state_d = vsmppt_pkg::ST_IDLE;
			end
			default: state_d = vsmppt_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= vsmppt_pkg::ST_IDLE;
			launched_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (unit_done)
				launched_q <= 1'b0;
			else if (mul_start || div_start || sq_start)
				launched_q <= 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pct_q <= vsmppt_pkg::MAX_STEP_RESET;
			min_pct_q <= vsmppt_pkg::MIN_STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				vsmppt_pkg::CFG_MAX_STEP: max_pct_q <= cfg_data;
				vsmppt_pkg::CFG_MIN_STEP: min_pct_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// request latch and intermediate results
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= voltage;
			p_q   <= power;
		end
		if (state_q == vsmppt_pkg::ST_T_DIFF)
			a_q <= dp_pos || dp_neg ? vsmppt_pkg::RATIO_MAX : '0;
		if (state_q == vsmppt_pkg::ST_T_DIV && div_done)
			a_q <= (div_quo > {17'd0, vsmppt_pkg::RATIO_MAX}) ?
				vsmppt_pkg::RATIO_MAX : div_quo[30:0];
		if (state_q == vsmppt_pkg::ST_T_SQP && sq_done)
			sp_q <= sq_root[13:0];
		if (state_q == vsmppt_pkg::ST_T_MULC && mul_done)
			c_q <= mul_prod[44:0];
		if (state_q == vsmppt_pkg::ST_T_MULA2 && mul_done)
			sqd_in_q <= mul_prod + 64'h1_0000_0000;
		if (state_q == vsmppt_pkg::ST_T_SQD && sq_done)
			d_q <= sq_root;
		if (state_q == vsmppt_pkg::ST_T_MULS && mul_done)
			num_q <= mul_prod[46:0];
		if (state_q == vsmppt_pkg::ST_T_DIVS && div_done)
			s_q <= div_quo;
	end

	// tracking state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_voltage_q  <= '0;
			last_power_q    <= '0;
			reference_q     <= '0;
			tracked_power_q <= '0;
			step_ceiling_q  <= '0;
			step_floor_q    <= '0;
			last_curv_q     <= '0;
		end else begin
			if (state_q == vsmppt_pkg::ST_R_DIV0 && div_done)
				reference_q <= div_quo[15:0];
			if (state_q == vsmppt_pkg::ST_R_DIV1 && div_done)
				step_ceiling_q <= pct_sat;
			if (state_q == vsmppt_pkg::ST_R_DIV2 && div_done) begin
				step_floor_q    <= pct_sat;
				last_voltage_q  <= v_q;
				last_power_q    <= '0;
				tracked_power_q <= '0;
			end
			if (state_q == vsmppt_pkg::ST_T_FIN && slot_free) begin
				reference_q    <= ref_new;
				last_power_q   <= p_q;
				last_voltage_q <= v_q;
				last_curv_q    <= c_ext;
				if (floored)
					tracked_power_q <= p_q;
			end
		end
	end

	// output register: load a finished result or drop the one taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			held_q      <= 1'b0;
			out_ref_q   <= '0;
			out_step_q  <= '0;
		end else if (slot_free) begin
			if (state_q == vsmppt_pkg::ST_R_FIN) begin
				out_valid_q <= 1'b1;
				out_ref_q   <= reference_q;
				out_step_q  <= '0;
				held_q      <= 1'b0;
			end else if (state_q == vsmppt_pkg::ST_T_DIFF && in_band) begin
				out_valid_q <= 1'b1;
				out_ref_q   <= reference_q;
				out_step_q  <= '0;
				held_q      <= 1'b1;
			end else if (state_q == vsmppt_pkg::ST_T_FIN) begin
				out_valid_q <= 1'b1;
				out_ref_q   <= ref_new;
				out_step_q  <= step_new;
				held_q      <= 1'b0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign reference_voltage = out_ref_q;
	assign applied_step      = $signed(out_step_q);
	assign held              = held_q;
endmodule

// ===== rtl/vsmppt_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on vsmppt_pkg.
module vsmppt_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [vsmppt_pkg::MUL_W-1:0]      a,
	input  logic [vsmppt_pkg::MUL_W-1:0]      b,
	output logic                              busy,
	output logic                              done,
	output logic [2*vsmppt_pkg::MUL_W-1:0]    prod
);
	localparam int W = vsmppt_pkg::MUL_W;

	logic [W-1:0]   mcand_q;
	logic [2*W-1:0] prod_q;
	logic [5:0]     cnt_q;
	logic           busy_q, done_q;
	logic [W:0]     sum;

	// add the multiplicand into the upper half when the low bit is set
	assign sum = {1'b0, prod_q[2*W-1:W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			mcand_q <= '0;
			prod_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				mcand_q <= a;
				prod_q  <= {{W{1'b0}}, b};
				cnt_q   <= 6'(W);
				busy_q  <= 1'b1;
			end else if (busy_q) begin
				prod_q <= {sum, prod_q[W-1:1]};
				cnt_q  <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = prod_q;
endmodule

// ===== rtl/vsmppt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on vsmppt_pkg.
module vsmppt_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vsmppt_pkg::DIVN_W-1:0] num,
	input  logic [vsmppt_pkg::DIVD_W-1:0] den,
	output logic                          busy,
	output logic                          done,
	output logic [vsmppt_pkg::DIVN_W-1:0] quo
);
	localparam int N = vsmppt_pkg::DIVN_W;
	localparam int D = vsmppt_pkg::DIVD_W;

	logic [N-1:0] q_q;
	logic [D-1:0] den_q, rem_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q;
	logic [D:0]   trial, diff;
	logic         ge;

	// shift in the next numerator bit and try a subtract
	assign trial = {rem_q, q_q[N-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			q_q    <= '0;
			den_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				q_q    <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= 6'(N);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[D-1:0] : trial[D-1:0];
				q_q   <= {q_q[N-2:0], ge};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = q_q;
endmodule

// ===== rtl/vsmppt_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
// Depends on vsmppt_pkg.
module vsmppt_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vsmppt_pkg::SQI_W-1:0] x,
	output logic                         busy,
	output logic                         done,
	output logic [vsmppt_pkg::SQO_W-1:0] root
);
	localparam int XW = vsmppt_pkg::SQI_W;
	localparam int RW = vsmppt_pkg::SQO_W;

	logic [XW-1:0] x_q;
	logic [RW-1:0] root_q;
	logic [RW+1:0] rem_q;
	logic [5:0]    cnt_q;
	logic          busy_q, done_q;
	logic [RW+3:0] remx, trial, diff;
	logic          ge;

	// bring down two bits, test root*4+1
	assign remx  = {rem_q, x_q[XW-1:XW-2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign ge    = remx >= trial;
	assign diff  = remx - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			root_q <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				x_q    <= x;
				root_q <= '0;
				rem_q  <= '0;
				cnt_q  <= 6'(RW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[RW+1:0] : remx[RW+1:0];
				root_q <= {root_q[RW-2:0], ge};
				x_q    <= {x_q[XW-3:0], 2'b00};
				cnt_q  <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;
endmodule

// ===== rtl/vsmppt_checker.sv =====
// Port-level checks for the MPPT tracker, attached by bind.
// Depends only on the top level's ports.
module vsmppt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [15:0]         reference_voltage,
	input logic signed [16:0]  applied_step,
	input logic                held
);
	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// stalled result does not change
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(reference_voltage) && $stable(applied_step))
		else $error("result changed while stalled");

	// a held result never carries a step
	a_held_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && held |-> applied_step == 17'sd0)
		else $error("held result with nonzero step");

	// the block is busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while still idle");
endmodule

bind variable_step_mppt_tracker vsmppt_checker u_vsmppt_checker (.*);
